// ===== src/pcl_pkg.sv =====
// Shared types and constants of the press code lock.
`timescale 1ns / 1ps
package pcl_pkg;

  // Event codes reported with each item
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_ACCEPT   = 3'd1;
  localparam logic [2:0] EV_COMPLETE = 3'd2;
  localparam logic [2:0] EV_FAIL     = 3'd3;
  localparam logic [2:0] EV_LOCKOUT  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_CODE_PATTERN = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd2;
  localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_MAX_FAILURES = 3'd4;

  // Register reset values
  localparam logic [7:0]  RST_CODE_PATTERN = 8'd173;
  localparam logic [15:0] RST_LONG_PRESS   = 16'd1000;
  localparam logic [15:0] RST_DEBOUNCE     = 16'd100;
  localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd5000;
  localparam logic [1:0]  RST_MAX_FAILURES = 2'd3;

  // Code bits held in the pattern register
  localparam int PATTERN_BITS = 8;

  typedef struct packed {
    logic [7:0]  code_pattern;
    logic [15:0] long_press_ticks;
    logic [15:0] debounce_ticks;
    logic [15:0] idle_timeout_ticks;
    logic [1:0]  max_failures;
  } cfg_t;

  typedef struct packed {
    logic [1:0] failures_so_far;
    logic [2:0] entered_count;
    logic [2:0] event_res;
  } result_t;

endpackage

// ===== src/press_code_lock.sv =====
// Path: an accepted item waits in the input register and moves into the result register when that register can take it.
// Throughput: one item per cycle while out_tready keeps the result register free; the step logic between
// the input register and the result register updates the lock state once for every item.
// Reset: synchronous active-low rst_n clears the lock state and both stage valids
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
module press_code_lock #(
  parameter int CODE_LENGTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] button_down, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] event_res, [5:3] entered_count, [7:6] failures_so_far
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  pcl_pkg::cfg_t    cfg;
  pcl_pkg::result_t res;
  logic             ld_ready;
  logic             step;
  logic             step_down;

  pcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcl_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .button_down (in_tdata[0]),
    .ld_ready    (ld_ready),
    .step        (step),
    .step_down   (step_down)
  );

  pcl_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .down  (step_down),
    .res   (res)
  );

  pcl_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .ld_ready   (ld_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  // A stepped item always shows up as a result next cycle
  a_step_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("stepped item did not reach the result register");

  // The failure count wraps to zero before it can reach three
  a_fail_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:6] != 2'd3))
    else $error("failure count out of range");

  // A completed code clears the entry and the failure count
  a_complete_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] == pcl_pkg::EV_COMPLETE)) |->
      (out_tdata[5:3] == 3'd0 && out_tdata[7:6] == 2'd0))
    else $error("code complete left state behind");

  // A lockout clears the failure count and the entry
  a_lockout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] == pcl_pkg::EV_LOCKOUT)) |->
      (out_tdata[5:3] == 3'd0 && out_tdata[7:6] == 2'd0))
    else $error("lockout left state behind");
`endif

endmodule

// ===== src/pcl_cfg_regs.sv =====
// Configuration register bank of the press code lock.
`timescale 1ns / 1ps
module pcl_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata,
  output pcl_pkg::cfg_t cfg
);

  pcl_pkg::cfg_t cfg_r;
  pcl_pkg::cfg_t cfg_nxt;

  // Decode the write; ignore indexes past the register list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        pcl_pkg::REG_CODE_PATTERN: cfg_nxt.code_pattern       = cfg_wdata[7:0];
        pcl_pkg::REG_LONG_PRESS:   cfg_nxt.long_press_ticks   = cfg_wdata;
        pcl_pkg::REG_DEBOUNCE:     cfg_nxt.debounce_ticks     = cfg_wdata;
        pcl_pkg::REG_IDLE_TIMEOUT: cfg_nxt.idle_timeout_ticks = cfg_wdata;
        pcl_pkg::REG_MAX_FAILURES: cfg_nxt.max_failures       = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_pattern       <= pcl_pkg::RST_CODE_PATTERN;
      cfg_r.long_press_ticks   <= pcl_pkg::RST_LONG_PRESS;
      cfg_r.debounce_ticks     <= pcl_pkg::RST_DEBOUNCE;
      cfg_r.idle_timeout_ticks <= pcl_pkg::RST_IDLE_TIMEOUT;
      cfg_r.max_failures       <= pcl_pkg::RST_MAX_FAILURES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/pcl_in_stage.sv =====
// Input register of the press code lock.
`timescale 1ns / 1ps
module pcl_in_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic button_down,
  input  logic ld_ready,
  output logic step,
  output logic step_down
);

  logic valid_r;
  logic valid_nxt;
  logic down_r;

  // Item leaves when the result register can take it
  assign step      = valid_r && ld_ready;
  assign in_tready = !valid_r || ld_ready;
  assign step_down = down_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the button level of the waiting item
  always_ff @(posedge clk) begin
    if (in_tready) begin
      down_r <= button_down;
    end
  end

endmodule

// ===== src/pcl_core.sv =====
// Lock state and per-tick step logic of the press code lock.
`timescale 1ns / 1ps
module pcl_core #(
  parameter int CODE_LENGTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pcl_pkg::cfg_t    cfg,
  input  logic             step,
  input  logic             down,
  output pcl_pkg::result_t res
);

  localparam int PW = (CODE_LENGTH > 2) ? $clog2(CODE_LENGTH) : 1;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [1:0]    fail_r, fail_nxt;
  logic          act_r, act_nxt;
  logic          deb_r, deb_nxt;
  logic [15:0]   held_r, held_nxt;
  logic [15:0]   idle_r, idle_nxt;

  logic [15:0] held_inc;
  logic [15:0] idle_inc;
  logic [3:0]  pos_ext;
  logic [4:0]  pos_plus;
  logic [1:0]  fail_inc;
  logic        fail_lock;
  logic        exp_sym;
  logic        sym;
  logic        timeout;
  logic [2:0]  ev;

  // Saturating tick counters
  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign held_inc = ((deb_r || act_r) && (held_r != 16'hFFFF)) ? held_r + 16'd1 : held_r;

  // Expected symbol; positions past the pattern expect a short press
  assign pos_ext  = 4'(pos_r);
  assign pos_plus = 5'(pos_r) + 5'd1;
  assign exp_sym  = pos_ext[3] ? 1'b0 : cfg.code_pattern[pos_ext[2:0]];
  assign sym      = (held_inc >= cfg.long_press_ticks);

  assign fail_inc  = fail_r + 2'd1;
  assign fail_lock = (fail_inc >= cfg.max_failures);
  assign timeout   = !down && (pos_r != '0) && (idle_inc >= cfg.idle_timeout_ticks);

  // One tick step
  always_comb begin
    pos_nxt  = pos_r;
    fail_nxt = fail_r;
    act_nxt  = act_r;
    deb_nxt  = deb_r;
    held_nxt = held_inc;
    idle_nxt = idle_inc;
    ev       = pcl_pkg::EV_NONE;
    if (deb_r) begin
      // Resample the button once debounce time is up
      if (held_inc >= cfg.debounce_ticks) begin
        deb_nxt = 1'b0;
        act_nxt = down;
      end
    end else begin
      // Abort a partial entry left idle too long
      if (timeout) begin
        pos_nxt  = '0;
        act_nxt  = 1'b0;
        fail_nxt = fail_lock ? 2'd0 : fail_inc;
        ev       = fail_lock ? pcl_pkg::EV_LOCKOUT : pcl_pkg::EV_FAIL;
      end
      // Class the press on release and check it against the code
      if (act_nxt && !down) begin
        act_nxt  = 1'b0;
        idle_nxt = 16'd0;
        if (sym == exp_sym) begin
          if (pos_plus >= 5'(CODE_LENGTH)) begin
            pos_nxt  = '0;
            fail_nxt = 2'd0;
            ev       = pcl_pkg::EV_COMPLETE;
          end else begin
            pos_nxt = PW'(pos_plus);
            ev      = pcl_pkg::EV_ACCEPT;
          end
        end else begin
          pos_nxt  = '0;
          fail_nxt = fail_lock ? 2'd0 : fail_inc;
          ev       = fail_lock ? pcl_pkg::EV_LOCKOUT : pcl_pkg::EV_FAIL;
        end
      end
      // Start debounce on a new press edge
      if (!act_nxt && down) begin
        deb_nxt  = 1'b1;
        held_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fail_r <= 2'd0;
      act_r  <= 1'b0;
      deb_r  <= 1'b0;
      held_r <= 16'd0;
      idle_r <= 16'd0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      fail_r <= fail_nxt;
      act_r  <= act_nxt;
      deb_r  <= deb_nxt;
      held_r <= held_nxt;
      idle_r <= idle_nxt;
    end
  end

  assign res.event_res       = ev;
  assign res.entered_count   = 4'(pos_nxt) > 4'd0 ? 3'(pos_nxt) : 3'd0;
  assign res.failures_so_far = fail_nxt;

endmodule

// ===== src/pcl_out_stage.sv =====
// Result register of the press code lock.
`timescale 1ns / 1ps
module pcl_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pcl_pkg::result_t res,
  output logic             ld_ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata
);

  logic             valid_r;
  logic             valid_nxt;
  pcl_pkg::result_t res_r;

  // Free when empty or being drained this cycle
  assign ld_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (ld_ready) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the press code lock: directed corner settings and random entries.
`timescale 1ns / 1ps
module tb;

  localparam int CODE_LEN        = 8;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int HOLD_OFF_AFTER  = 400;    // results checked before the long receiver stall
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [2:0] REG_UNUSED_BASE = pcl_pkg::REG_MAX_FAILURES + 3'd1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [0] button_down, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [2:0] event_res, [5:3] entered_count, [7:6] failures_so_far
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  int idle_pct      = 0;
  int settings_used = 0;
  int cycle_count   = 0;
  bit pressure_done = 1'b0;

  // Lock predictor and store of expected events
  class lock_checker;
    logic [7:0]  code_pattern;
    logic [15:0] long_ticks;
    logic [15:0] debounce_ticks;
    logic [15:0] idle_limit;
    logic [1:0]  max_fail;

    int          position;
    logic [1:0]  fail_count;
    bit          press_active;
    bit          debouncing;
    logic [15:0] held;
    logic [15:0] idle;

    pcl_pkg::result_t expected_events[$];
    int      ticks;
    int      checked;
    int      mismatches;
    int      ev_seen[5];

    function new();
      code_pattern   = pcl_pkg::RST_CODE_PATTERN;
      long_ticks     = pcl_pkg::RST_LONG_PRESS;
      debounce_ticks = pcl_pkg::RST_DEBOUNCE;
      idle_limit     = pcl_pkg::RST_IDLE_TIMEOUT;
      max_fail       = pcl_pkg::RST_MAX_FAILURES;
      position       = 0;
      fail_count     = '0;
      press_active   = 1'b0;
      debouncing     = 1'b0;
      held           = '0;
      idle           = '0;
      ticks          = 0;
      checked        = 0;
      mismatches     = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        pcl_pkg::REG_CODE_PATTERN: code_pattern   = val[7:0];
        pcl_pkg::REG_LONG_PRESS:   long_ticks     = val;
        pcl_pkg::REG_DEBOUNCE:     debounce_ticks = val;
        pcl_pkg::REG_IDLE_TIMEOUT: idle_limit     = val;
        pcl_pkg::REG_MAX_FAILURES: max_fail       = val[1:0];
        default: ;
      endcase
    endfunction

    function bit next_symbol();
      if (position >= pcl_pkg::PATTERN_BITS) return 1'b0;
      return code_pattern[position];
    endfunction

    // Clear the entry and count a failure; a count at the limit turns into a lockout
    function logic [2:0] register_failure();
      position     = 0;
      press_active = 1'b0;
      fail_count   = fail_count + 2'd1;
      if (fail_count >= max_fail) begin
        fail_count = '0;
        return pcl_pkg::EV_LOCKOUT;
      end
      return pcl_pkg::EV_FAIL;
    endfunction

    // Advance the lock by one tick and queue the event it reports
    function void take_tick(logic down);
      pcl_pkg::result_t r;
      logic [2:0] ev;
      ev = pcl_pkg::EV_NONE;
      if (idle != 16'hFFFF) idle = idle + 16'd1;
      if ((debouncing || press_active) && held != 16'hFFFF) held = held + 16'd1;
      if (debouncing) begin
        if (held >= debounce_ticks) begin
          debouncing   = 1'b0;
          press_active = down;
        end
      end else begin
        // Idle timeout during a partial entry
        if (!down && position > 0 && idle >= idle_limit) ev = register_failure();
        // Release: class the press and compare it with the code
        if (press_active && !down) begin
          press_active = 1'b0;
          idle         = '0;
          if ((held >= long_ticks) == next_symbol()) begin
            position = position + 1;
            if (position >= CODE_LEN) begin
              position   = 0;
              fail_count = '0;
              ev         = pcl_pkg::EV_COMPLETE;
            end else begin
              ev = pcl_pkg::EV_ACCEPT;
            end
          end else begin
            ev = register_failure();
          end
        end
        // Press edge: start the debounce interval
        if (!press_active && down) begin
          debouncing = 1'b1;
          held       = '0;
        end
      end
      r.event_res       = ev;
      r.entered_count   = 3'(position);
      r.failures_so_far = fail_count;
      expected_events.push_back(r);
      ev_seen[ev]++;
      ticks++;
    endfunction

    // Compare one result item with the oldest expected event
    function void check_event(logic [7:0] raw);
      pcl_pkg::result_t got;
      pcl_pkg::result_t want;
      got = pcl_pkg::result_t'(raw);
      checked++;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: event %0d count %0d failures %0d",
                   $realtime, got.event_res, got.entered_count, got.failures_so_far);
        return;
      end
      want = expected_events.pop_front();
      if (got.event_res !== want.event_res || got.entered_count !== want.entered_count ||
          got.failures_so_far !== want.failures_so_far) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch on result %0d: event %0d/%0d count %0d/%0d failures %0d/%0d",
                   $realtime, checked, want.event_res, got.event_res, want.entered_count,
                   got.entered_count, want.failures_so_far, got.failures_so_far);
      end
    endfunction
  endclass

  lock_checker chk = new();

  press_code_lock #(
    .CODE_LENGTH(CODE_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Note accepted items and check accepted results
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) chk.take_tick(in_tdata[0]);
    if (rst_n && out_tvalid && out_tready) chk.check_event(out_tdata);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               chk.expected_events.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int pause_len();
    return ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
  endfunction

  // Receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && chk.checked >= HOLD_OFF_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  end

  // Offer one tick item and hold it until accepted
  task automatic press_tick(bit down);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat (pause_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, down};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic hold_level(bit down, int n);
    repeat (n) press_tick(down);
  endtask

  // Stop offering and wait for every expected event
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chk.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    chk.write_reg(idx, val);
  endtask

  // Load all registers, then poke an unused index that must be ignored
  task automatic set_lock(logic [7:0] pattern, logic [15:0] long_t, logic [15:0] deb_t,
                          logic [15:0] idle_t, logic [1:0] maxf);
    write_reg(pcl_pkg::REG_CODE_PATTERN, 16'(pattern));
    write_reg(pcl_pkg::REG_LONG_PRESS, long_t);
    write_reg(pcl_pkg::REG_DEBOUNCE, deb_t);
    write_reg(pcl_pkg::REG_IDLE_TIMEOUT, idle_t);
    write_reg(pcl_pkg::REG_MAX_FAILURES, 16'(maxf));
    write_reg(3'(REG_UNUSED_BASE + 3'($urandom_range(2))), 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Mostly well-formed presses aimed at the code, with bounces and noise mixed in
  task automatic run_entries(int n);
    int sent;
    int lo;
    int h;
    int u;
    int r;
    int deb;
    int lng;
    int tmo;
    bit want_long;
    sent = 0;
    deb  = chk.debounce_ticks;
    lng  = chk.long_ticks;
    tmo  = chk.idle_limit;
    lo   = ((deb > 1) ? deb : 1) + 1;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 75) begin
        // Roughly track the next expected symbol; a few presses go wrong on purpose
        want_long = ($urandom_range(9) != 0) ? chk.next_symbol() : 1'($urandom_range(1));
        if (want_long) h = ((lng > lo) ? lng : lo) + $urandom_range(3);
        else if (lng - 1 >= lo) h = $urandom_range(lng - 1, lo);
        else h = lo;
        u = ($urandom_range(99) < 85 && tmo > 1) ? $urandom_range(tmo - 1, 1)
                                                  : tmo + $urandom_range(3);
        hold_level(1'b1, h);
        hold_level(1'b0, u);
        sent += h + u;
      end else if (r < 87) begin
        // Bounce released before the debounce sample
        h = $urandom_range(lo - 1, 1);
        u = $urandom_range(3, 1);
        hold_level(1'b1, h);
        hold_level(1'b0, u);
        sent += h + u;
      end else begin
        h = $urandom_range(8, 1);
        repeat (h) press_tick(1'($urandom_range(1)));
        sent += h;
      end
    end
    drain();
  endtask

  initial begin
    int failures;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-zero timing: every press long, every idle tick times out, every failure locks
    idle_pct = 25;
    set_lock(8'hFF, 16'd0, 16'd0, 16'd0, 2'd0);
    hold_level(1'b1, 2);
    hold_level(1'b0, 2);
    press_tick(1'b1);
    press_tick(1'b0);
    hold_level(1'b1, 3);
    press_tick(1'b0);
    drain();

    // Short press accepted, then a wrong long press locks out at once
    set_lock(8'h00, 16'd3, 16'd1, 16'd4, 2'd1);
    hold_level(1'b1, 2);
    press_tick(1'b0);
    hold_level(1'b1, 4);
    press_tick(1'b0);
    drain();

    // Random settings with small timing so entries run deep
    for (int p = 0; p < 6; p++) begin
      int deb;
      deb      = $urandom_range(6);
      idle_pct = (p % 3 == 1) ? 0 : 30;
      set_lock((p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom),
               16'(deb + $urandom_range(12, 1)), 16'(deb), 16'($urandom_range(30, 3)),
               (p == 2) ? 2'd0 : 2'($urandom_range(3)));
      run_entries(170);
    end
    drain();

    failures = chk.mismatches + chk.expected_events.size();
    $display("Run covered %0d ticks under %0d lock settings, zero timing and a long stall.",
             chk.ticks, settings_used);
    $display("Events: %0d accepted, %0d complete, %0d failures, %0d lockouts; %0d bad results.",
             chk.ev_seen[pcl_pkg::EV_ACCEPT], chk.ev_seen[pcl_pkg::EV_COMPLETE],
             chk.ev_seen[pcl_pkg::EV_FAIL], chk.ev_seen[pcl_pkg::EV_LOCKOUT], failures);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
